// File: hw/rtl/gop_pkg.sv
`timescale 1ns / 1ps

package gop_pkg;

  localparam int ROWS          = 4;
  localparam int COLS          = 8;
  localparam int ROW_W         = $clog2(ROWS);
  localparam int OPND_W        = 16;
  localparam int PROD_W        = 2 * OPND_W;
  localparam int ACC_W         = 40;
  localparam int K_DEPTH_W     = 7;
  localparam int K_MAX_DEFAULT = 64;

  localparam logic [K_DEPTH_W-1:0] K_DEPTH_RESET = K_DEPTH_W'(64);

  typedef logic [COLS-1:0][ACC_W-1:0] acc_row_t;
  typedef acc_row_t [ROWS-1:0]        acc_tile_t;
  typedef logic [COLS-1:0][OPND_W-1:0] b_row_t;

  // product stage control, shared by all lanes
  typedef struct packed {
    logic valid;
    logic done;
  } gop_step_t;

endpackage

// File: hw/rtl/gop_lane.sv
`timescale 1ns / 1ps

module gop_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  gop_pkg::gop_step_t                step_i,
  input  logic [gop_pkg::OPND_W-1:0]        a_i,
  input  gop_pkg::b_row_t                   b_i,
  output gop_pkg::acc_row_t                 sum_o
);

  logic signed [gop_pkg::PROD_W-1:0] prod_q [gop_pkg::COLS];
  logic [gop_pkg::ACC_W-1:0]         acc_q  [gop_pkg::COLS];

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int c = 0; c < gop_pkg::COLS; c++) begin
        prod_q[c] <= $signed(a_i) * $signed(b_i[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < gop_pkg::COLS; c++) begin
      sum_o[c] = acc_q[c] + {{(gop_pkg::ACC_W - gop_pkg::PROD_W){prod_q[c][gop_pkg::PROD_W-1]}},
                             prod_q[c]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < gop_pkg::COLS; c++) begin
        acc_q[c] <= '0;
      end
    end else if (step_i.valid) begin
      for (int c = 0; c < gop_pkg::COLS; c++) begin
        acc_q[c] <= step_i.done ? '0 : sum_o[c];
      end
    end
  end

endmodule

// File: hw/rtl/gop_merge.sv
`timescale 1ns / 1ps

module gop_merge (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       load_i,
  input  gop_pkg::acc_tile_t                         sums_i,
  input  logic                                       m_axis_tready_i,
  output logic                                       m_axis_tvalid_o,
  output logic [gop_pkg::COLS*gop_pkg::ACC_W-1:0]    m_axis_tdata_o,
  output logic                                       m_axis_tlast_o,
  output logic [gop_pkg::ROW_W-1:0]                  m_axis_tuser_o,
  output logic                                       busy_o
);

  localparam logic [gop_pkg::ROW_W-1:0] LastRow = gop_pkg::ROW_W'(gop_pkg::ROWS - 1);

  logic [gop_pkg::COLS*gop_pkg::ACC_W-1:0] buf_q [gop_pkg::ROWS];
  logic                                    busy_q, busy_d;
  logic [gop_pkg::ROW_W-1:0]               row_q, row_d;
  logic                                    m_fire;

  assign m_fire = busy_q && m_axis_tready_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int r = 0; r < gop_pkg::ROWS; r++) begin
        buf_q[r] <= sums_i[r];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    row_d  = row_q;
    if (load_i) begin
      busy_d = 1'b1;
      row_d  = '0;
    end else if (m_fire) begin
      if (row_q == LastRow) begin
        busy_d = 1'b0;
      end
      row_d = row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      row_q  <= '0;
    end else begin
      busy_q <= busy_d;
      row_q  <= row_d;
    end
  end

  assign m_axis_tvalid_o = busy_q;
  assign m_axis_tdata_o  = buf_q[row_q];
  assign m_axis_tlast_o  = (row_q == LastRow);
  assign m_axis_tuser_o  = row_q;
  assign busy_o          = busy_q;

`ifndef NO_ASSERTIONS
  a_load_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !busy_q)
    else $error("tile loaded over undrained rows");

  a_last_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_fire && row_q == LastRow) |=> !busy_q)
    else $error("buffer still busy after last row");

  a_load_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (busy_q && row_q == '0))
    else $error("loaded tile does not start at row zero");
`endif

endmodule

// File: hw/rtl/gemm_outer_product_4x8_top.sv
// A completing request passes the product registers, then its tile is loaded into the
//   output buffer; its four rows follow on consecutive cycles while m_axis_tready_i is high.
// Throughput: one request per cycle, set by the 32 lane MACs (multiply stage, then add stage).
//   A completing request waits while the previous tile is still being loaded into or
//   drained from the output buffer.
// Reset (rst_ni low, async): accumulators and step count cleared, k_depth = 64, no rows pending.
`timescale 1ns / 1ps

module gemm_outer_product_4x8_top #(
  parameter int K_MAX = gop_pkg::K_MAX_DEFAULT
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [gop_pkg::K_DEPTH_W-1:0]            cfg_wdata_i,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // a_row0..a_row3, b_col0..b_col7, 16 bits each
  input  logic [(gop_pkg::ROWS+gop_pkg::COLS)*gop_pkg::OPND_W-1:0] s_axis_tdata_i,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  // c_col0..c_col7, 40 bits each
  output logic [gop_pkg::COLS*gop_pkg::ACC_W-1:0]  m_axis_tdata_o,
  output logic                                     m_axis_tlast_o,
  // row_index
  output logic [gop_pkg::ROW_W-1:0]                m_axis_tuser_o
);

  localparam int CNT_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CMP_W = ((CNT_W > gop_pkg::K_DEPTH_W) ? CNT_W : gop_pkg::K_DEPTH_W) + 2;

  localparam logic [CMP_W-1:0] KMaxC = CMP_W'(K_MAX);
  localparam logic [CMP_W-1:0] OneC  = CMP_W'(1);

  logic [gop_pkg::K_DEPTH_W-1:0] k_depth_q;
  logic [CNT_W-1:0]              step_q, step_d;
  gop_pkg::gop_step_t            s1_q, s1_d;
  logic [CMP_W-1:0]              kd_ext, eff_depth, step_next;
  logic                          done_now, s_fire, busy, pending;
  gop_pkg::b_row_t               b_row;
  gop_pkg::acc_tile_t            sums;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_depth_q <= gop_pkg::K_DEPTH_RESET;
    end else if (cfg_we_i) begin
      k_depth_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    kd_ext = CMP_W'(k_depth_q);
    if (kd_ext == '0) begin
      eff_depth = OneC;
    end else if (kd_ext > KMaxC) begin
      eff_depth = KMaxC;
    end else begin
      eff_depth = kd_ext;
    end
    step_next = CMP_W'(step_q) + OneC;
    done_now  = (step_next >= eff_depth);
  end

  assign pending         = s1_q.valid && s1_q.done;
  assign s_axis_tready_o = !done_now || !(busy || pending);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    step_d = step_q;
    if (s_fire) begin
      step_d = done_now ? '0 : step_next[CNT_W-1:0];
    end
    s1_d.valid = s_fire;
    s1_d.done  = s_fire && done_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      s1_q   <= '0;
    end else begin
      step_q <= step_d;
      s1_q   <= s1_d;
    end
  end

  always_comb begin
    for (int c = 0; c < gop_pkg::COLS; c++) begin
      b_row[c] = s_axis_tdata_i[(gop_pkg::ROWS + c)*gop_pkg::OPND_W +: gop_pkg::OPND_W];
    end
  end

  for (genvar r = 0; r < gop_pkg::ROWS; r++) begin : g_lane
    gop_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .accept_i (s_fire),
      .step_i   (s1_q),
      .a_i      (s_axis_tdata_i[r*gop_pkg::OPND_W +: gop_pkg::OPND_W]),
      .b_i      (b_row),
      .sum_o    (sums[r])
    );
  end

  gop_merge u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (pending),
    .sums_i          (sums),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .busy_o          (busy)
  );

`ifndef NO_ASSERTIONS
  a_done_tracked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && done_now) |=> (s1_q.valid && s1_q.done && step_q == '0))
    else $error("completing request not tracked");

  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending |-> !busy)
    else $error("tile completes while output buffer busy");

  a_step_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && !done_now) |=> (step_q == $past(step_q) + 1'b1))
    else $error("step count did not advance");
`endif

endmodule
